@@ hdl/m3x3_pkg.sv @@
// ----------------------------------------------------------------------------
// m3x3_pkg
// Types and constants shared by the 3x3 matrix add/subtract/multiply core.
// ----------------------------------------------------------------------------
package m3x3_pkg;

  localparam int ELEM_W     = 16;  // Q8.8 element
  localparam int RES_W      = 32;  // result element
  localparam int PROD_W     = 32;  // full-precision Q16.16 product
  localparam int FRAC_W     = 8;
  localparam int OP_W       = 2;
  localparam int POS_W      = 2;   // row_index / column_index width
  localparam int IDX_W      = 3;   // row, column and term counters (DIM up to 8)
  localparam int ADDR_W     = 6;   // element address (DIM*DIM up to 64)

  localparam logic [OP_W-1:0] OP_SUB   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET = 2'd2;
  localparam int              OP_MUL_BIT = 1;  // set for multiply (codes 2 and 3)

  typedef enum logic [1:0] {
    S_LOAD,
    S_ISSUE,
    S_WAIT,
    S_PUT
  } st_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr;        // store the accepted pair
    logic [ADDR_W-1:0] wr_addr;
    logic              sample_op; // latch the operation for this batch
    logic              issue;     // read one term pair
    logic              first;     // first term of the current element
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  term;
    logic              put;       // load the output register
    logic              last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic op_mul;
  } stat_t;

endpackage

@@ hdl/m3x3_in_if.sv @@
// ----------------------------------------------------------------------------
// m3x3_in_if
// Input channel: one element pair of A and B per transaction.
// ----------------------------------------------------------------------------
interface m3x3_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [m3x3_pkg::ELEM_W-1:0] a_element;
  logic signed [m3x3_pkg::ELEM_W-1:0] b_element;

  modport source (output valid, a_element, b_element, input ready);
  modport sink   (input valid, a_element, b_element, output ready);
endinterface

@@ hdl/m3x3_out_if.sv @@
// ----------------------------------------------------------------------------
// m3x3_out_if
// Result channel: one result element per transaction.
// ----------------------------------------------------------------------------
interface m3x3_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [m3x3_pkg::RES_W-1:0] result_element;
  logic [m3x3_pkg::POS_W-1:0]        row_index;
  logic [m3x3_pkg::POS_W-1:0]        column_index;
  logic                               last_result;

  modport source (output valid, result_element, row_index, column_index, last_result,
                  input ready);
  modport sink   (input valid, result_element, row_index, column_index, last_result,
                  output ready);
endinterface

@@ hdl/m3x3_cfg_if.sv @@
// ----------------------------------------------------------------------------
// m3x3_cfg_if
// Configuration write channel for the operation register.
// ----------------------------------------------------------------------------
interface m3x3_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [m3x3_pkg::OP_W-1:0]    operation;

  modport source (output valid, operation, input ready);
  modport sink   (input valid, operation, output ready);
endinterface

@@ hdl/m3x3_ctrl.sv @@
// ----------------------------------------------------------------------------
// m3x3_ctrl
// Controller: counts the load, then walks the result elements and the terms
// of each element, and hands finished elements to the output register.
// ----------------------------------------------------------------------------
module m3x3_ctrl #(
  parameter int DIM = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  m3x3_pkg::stat_t   stat,
  output m3x3_pkg::cmd_t    cmd
);

  localparam logic [m3x3_pkg::ADDR_W-1:0] LOAD_LAST = m3x3_pkg::ADDR_W'(DIM * DIM - 1);
  localparam logic [m3x3_pkg::IDX_W-1:0]  IDX_LAST  = m3x3_pkg::IDX_W'(DIM - 1);

  m3x3_pkg::st_t                state_r, state_nxt;
  logic [m3x3_pkg::ADDR_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [m3x3_pkg::IDX_W-1:0]   row_r, row_nxt;
  logic [m3x3_pkg::IDX_W-1:0]   col_r, col_nxt;
  logic [m3x3_pkg::IDX_W-1:0]   term_r, term_nxt;
  logic                         wait_r, wait_nxt;
  logic                         in_fire;
  logic                         load_done;
  logic                         term_done;
  logic                         elem_last;

  assign in_fire   = in_valid && (state_r == m3x3_pkg::S_LOAD);
  assign load_done = in_fire && (load_cnt_r == LOAD_LAST);
  // Add and subtract take one term; multiply takes DIM of them.
  assign term_done = stat.op_mul ? (term_r == IDX_LAST) : 1'b1;
  assign elem_last = (row_r == IDX_LAST) && (col_r == IDX_LAST);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      m3x3_pkg::S_LOAD: begin
        if (load_done) state_nxt = m3x3_pkg::S_ISSUE;
      end
      m3x3_pkg::S_ISSUE: begin
        if (term_done) state_nxt = m3x3_pkg::S_WAIT;
      end
      m3x3_pkg::S_WAIT: begin
        if (wait_r) state_nxt = m3x3_pkg::S_PUT;
      end
      m3x3_pkg::S_PUT: begin
        if (stat.out_free) state_nxt = elem_last ? m3x3_pkg::S_LOAD : m3x3_pkg::S_ISSUE;
      end
      default: state_nxt = m3x3_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == m3x3_pkg::S_LOAD);
    cmd.wr        = in_fire;
    cmd.wr_addr   = load_cnt_r;
    cmd.sample_op = load_done;
    cmd.issue     = (state_r == m3x3_pkg::S_ISSUE);
    cmd.first     = (term_r == '0);
    cmd.row       = row_r;
    cmd.col       = col_r;
    cmd.term      = term_r;
    cmd.put       = (state_r == m3x3_pkg::S_PUT) && stat.out_free;
    cmd.last      = elem_last;
  end

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    term_nxt     = term_r;
    wait_nxt     = wait_r;
    case (state_r)
      m3x3_pkg::S_LOAD: begin
        if (in_fire) begin
          load_cnt_nxt = load_done ? '0 : load_cnt_r + 1'b1;
        end
        row_nxt  = '0;
        col_nxt  = '0;
        term_nxt = '0;
      end
      m3x3_pkg::S_ISSUE: begin
        term_nxt = term_done ? '0 : term_r + 1'b1;
        wait_nxt = 1'b0;
      end
      m3x3_pkg::S_WAIT: begin
        wait_nxt = 1'b1;
      end
      m3x3_pkg::S_PUT: begin
        if (stat.out_free && !elem_last) begin
          if (col_r == IDX_LAST) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= m3x3_pkg::S_LOAD;
      load_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      term_r     <= '0;
      wait_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      term_r     <= term_nxt;
      wait_r     <= wait_nxt;
    end
  end

endmodule

@@ hdl/m3x3_dp.sv @@
// ----------------------------------------------------------------------------
// m3x3_dp
// Datapath: element stores, operand read stage, product or sum stage,
// accumulator, rescale and the output register.
// ----------------------------------------------------------------------------
module m3x3_dp #(
  parameter int DIM = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  m3x3_pkg::cmd_t                      cmd,
  output m3x3_pkg::stat_t                     stat,
  input  logic signed [m3x3_pkg::ELEM_W-1:0]  a_element,
  input  logic signed [m3x3_pkg::ELEM_W-1:0]  b_element,
  input  logic                                cfg_valid,
  input  logic [m3x3_pkg::OP_W-1:0]           cfg_operation,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [m3x3_pkg::RES_W-1:0]   out_result,
  output logic [m3x3_pkg::POS_W-1:0]          out_row,
  output logic [m3x3_pkg::POS_W-1:0]          out_col,
  output logic                                out_last
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int ACC_W = m3x3_pkg::PROD_W + $clog2(DIM);

  logic signed [m3x3_pkg::ELEM_W-1:0] a_mem [CELLS];
  logic signed [m3x3_pkg::ELEM_W-1:0] b_mem [CELLS];

  logic [m3x3_pkg::OP_W-1:0]   cfg_op_r;
  logic [m3x3_pkg::OP_W-1:0]   act_op_r;
  logic                        op_mul;
  logic [m3x3_pkg::ADDR_W-1:0] row_base;
  logic [m3x3_pkg::ADDR_W-1:0] a_addr;
  logic [m3x3_pkg::ADDR_W-1:0] b_addr;

  logic signed [m3x3_pkg::ELEM_W-1:0] ra_r;
  logic signed [m3x3_pkg::ELEM_W-1:0] rb_r;
  logic                               v1_r, f1_r;
  logic signed [ACC_W-1:0]            prod_r, prod_nxt;
  logic                               v2_r, f2_r;
  logic signed [ACC_W-1:0]            acc_r;
  logic signed [ACC_W-1:0]            acc_sh;
  logic signed [m3x3_pkg::PROD_W-1:0] mul_val;
  logic signed [m3x3_pkg::ELEM_W:0]   lin_val;

  logic                               out_valid_r;
  logic signed [m3x3_pkg::RES_W-1:0]  res_nxt;
  logic signed [m3x3_pkg::RES_W-1:0]  out_result_r;
  logic [m3x3_pkg::POS_W-1:0]         out_row_r;
  logic [m3x3_pkg::POS_W-1:0]         out_col_r;
  logic                               out_last_r;

  assign op_mul = act_op_r[m3x3_pkg::OP_MUL_BIT];

  // Multiply reads A along the row and B down the column; add and subtract
  // read both stores at the element's own position.
  assign row_base = m3x3_pkg::ADDR_W'(cmd.row) * m3x3_pkg::ADDR_W'(DIM);
  assign a_addr   = op_mul ? row_base + m3x3_pkg::ADDR_W'(cmd.term)
                           : row_base + m3x3_pkg::ADDR_W'(cmd.col);
  assign b_addr   = op_mul ? m3x3_pkg::ADDR_W'(cmd.term) * m3x3_pkg::ADDR_W'(DIM)
                             + m3x3_pkg::ADDR_W'(cmd.col)
                           : row_base + m3x3_pkg::ADDR_W'(cmd.col);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      a_mem[cmd.wr_addr[AW-1:0]] <= a_element;
      b_mem[cmd.wr_addr[AW-1:0]] <= b_element;
    end
    ra_r <= a_mem[a_addr[AW-1:0]];
    rb_r <= b_mem[b_addr[AW-1:0]];
  end

  always_comb begin
    mul_val = ra_r * rb_r;
    if (act_op_r == m3x3_pkg::OP_SUB) begin
      lin_val = {ra_r[m3x3_pkg::ELEM_W-1], ra_r} - {rb_r[m3x3_pkg::ELEM_W-1], rb_r};
    end else begin
      lin_val = {ra_r[m3x3_pkg::ELEM_W-1], ra_r} + {rb_r[m3x3_pkg::ELEM_W-1], rb_r};
    end
    prod_nxt = op_mul ? ACC_W'(mul_val) : ACC_W'(lin_val);
  end

  always_ff @(posedge clk) begin
    if (v1_r) prod_r <= prod_nxt;
    if (v2_r) acc_r  <= (f2_r ? '0 : acc_r) + prod_r;
  end

  // The arithmetic shift rounds the product sum toward minus infinity.
  always_comb begin
    acc_sh  = acc_r >>> m3x3_pkg::FRAC_W;
    res_nxt = op_mul ? acc_sh[m3x3_pkg::RES_W-1:0] : acc_r[m3x3_pkg::RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      out_result_r <= res_nxt;
      out_row_r    <= cmd.row[m3x3_pkg::POS_W-1:0];
      out_col_r    <= cmd.col[m3x3_pkg::POS_W-1:0];
      out_last_r   <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_op_r    <= m3x3_pkg::OP_RESET;
      act_op_r    <= m3x3_pkg::OP_RESET;
      v1_r        <= 1'b0;
      f1_r        <= 1'b0;
      v2_r        <= 1'b0;
      f2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) cfg_op_r <= cfg_operation;
      // A write that lands on the completing transaction is seen by that batch.
      if (cmd.sample_op) act_op_r <= cfg_valid ? cfg_operation : cfg_op_r;
      v1_r <= cmd.issue;
      f1_r <= cmd.first;
      v2_r <= v1_r;
      f2_r <= f1_r;
      if (cmd.put) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.op_mul   = op_mul;

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_last   = out_last_r;

endmodule

@@ hdl/matrix3x3_add_sub_multiply_core.sv @@
// ----------------------------------------------------------------------------
// matrix3x3_add_sub_multiply_core
// DIM x DIM matrix add, subtract or multiply on Q8.8 elements.
// ----------------------------------------------------------------------------
// Element pairs of A and B arrive in row-major order, one per transaction and
// one per cycle while loading. The operation in effect at the transaction that
// completes the load applies to that batch. After the last pair the DIM*DIM
// results leave in row-major order with last_result set on the final one; no
// input is taken until the last result has entered the output register. Each
// multiply element runs its DIM terms through one shared read, multiply and
// accumulate pipeline, and an add or subtract element runs one term through it.
// Products are summed at full precision and shifted right by 8, rounding toward
// minus infinity. The operation register resets to multiply.
module matrix3x3_add_sub_multiply_core #(
  parameter int DIM = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  m3x3_in_if.sink       in_ch,
  m3x3_out_if.source    out_ch,
  m3x3_cfg_if.sink      cfg_ch
);

  m3x3_pkg::cmd_t  cmd;
  m3x3_pkg::stat_t stat;
  logic            in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  m3x3_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  m3x3_dp #(
    .DIM (DIM)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .a_element     (in_ch.a_element),
    .b_element     (in_ch.b_element),
    .cfg_valid     (cfg_ch.valid),
    .cfg_operation (cfg_ch.operation),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_result    (out_ch.result_element),
    .out_row       (out_ch.row_index),
    .out_col       (out_ch.column_index),
    .out_last      (out_ch.last_result)
  );

endmodule

@@ tb/sv/matrix3x3_add_sub_multiply_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3x3_add_sub_multiply_core_tb
// Self-checking testbench for the 3x3 matrix add/subtract/multiply core.
// A short table of element pairs covers the extremes, every operation code,
// a change of operation in the middle of a load and floor rounding of
// products. Random batches with random operation changes and random stalls
// on both channels follow. Every result is checked against the table's value or a
// software matrix calculator kept in step with the accepted transactions.
// ----------------------------------------------------------------------------
module matrix3x3_add_sub_multiply_core_tb;

  localparam int DIM            = 3;
  localparam int CELLS          = DIM * DIM;
  localparam int MAX_GAP        = 6;
  localparam int SETTLE         = 12;
  localparam int TAIL           = 40;
  localparam int RANDOM_BATCHES = 44;
  localparam int CYCLE_LIMIT    = 200000;

  localparam logic [m3x3_pkg::OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [m3x3_pkg::OP_W-1:0] OP_MUL     = 2'd2;
  localparam logic [m3x3_pkg::OP_W-1:0] OP_MUL_ALT = 2'd3;

  localparam logic [m3x3_pkg::ELEM_W-1:0] B_MIX [CELLS] = '{
    16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0100,
    16'h1234, 16'hEDCB, 16'h0000, 16'h00FF
  };

  typedef enum {FILL_WIDE, FILL_NARROW, FILL_EDGE} fill_t;

  typedef struct packed {
    logic signed [m3x3_pkg::RES_W-1:0] value;
    logic [m3x3_pkg::POS_W-1:0]        row;
    logic [m3x3_pkg::POS_W-1:0]        col;
    logic                              last;
  } cell_t;

  typedef struct packed {
    logic                              typed;
    logic signed [m3x3_pkg::RES_W-1:0] want;
  } tag_t;

  typedef struct packed {
    logic                              set_op;
    logic [m3x3_pkg::OP_W-1:0]         op;
    logic [m3x3_pkg::ELEM_W-1:0]       a;
    logic [m3x3_pkg::ELEM_W-1:0]       b;
    logic                              typed;
    logic signed [m3x3_pkg::RES_W-1:0] want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  m3x3_in_if  in_ch ();
  m3x3_out_if out_ch ();
  m3x3_cfg_if cfg_ch ();

  matrix3x3_add_sub_multiply_core #(
    .DIM (DIM)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Calculator state, updated only by accepted transactions.
  logic signed [m3x3_pkg::ELEM_W-1:0] a_mem [CELLS];
  logic signed [m3x3_pkg::ELEM_W-1:0] b_mem [CELLS];
  tag_t                               tag_mem [CELLS];
  int                                 load_pos = 0;
  logic [m3x3_pkg::OP_W-1:0]          model_op = m3x3_pkg::OP_RESET;

  cell_t     pending_results [$];
  tag_t      typed_tags [$];
  stim_row_t directed_rows [$];

  int   errors = 0;
  int   results_checked = 0;
  int   batches_by_op [4] = '{0, 0, 0, 0};
  int   cycles = 0;
  logic src_quiet = 1'b0;
  logic snk_quiet = 1'b0;
  // Set while the source holds valid high from its last transaction.
  logic src_driving = 1'b0;

  function automatic logic signed [m3x3_pkg::RES_W-1:0] result_cell(
      int r, int c, logic [m3x3_pkg::OP_W-1:0] op);
    logic signed [47:0] acc;
    int                 i;
    int                 k;
    i = r * DIM + c;
    if (op[m3x3_pkg::OP_MUL_BIT]) begin
      acc = '0;
      for (k = 0; k < DIM; k++) acc = acc + a_mem[r * DIM + k] * b_mem[k * DIM + c];
      // Arithmetic shift gives the floor of the rescaled sum.
      return m3x3_pkg::RES_W'(acc >>> m3x3_pkg::FRAC_W);
    end
    if (op == m3x3_pkg::OP_SUB) return a_mem[i] - b_mem[i];
    return a_mem[i] + b_mem[i];
  endfunction

  function automatic stim_row_t make_row(logic set_op, logic [m3x3_pkg::OP_W-1:0] op,
                                         logic [m3x3_pkg::ELEM_W-1:0] a,
                                         logic [m3x3_pkg::ELEM_W-1:0] b,
                                         logic typed,
                                         logic signed [m3x3_pkg::RES_W-1:0] want);
    stim_row_t row;
    row.set_op = set_op;
    row.op     = op;
    row.a      = a;
    row.b      = b;
    row.typed  = typed;
    row.want   = want;
    return row;
  endfunction

  function automatic logic [m3x3_pkg::ELEM_W-1:0] pick_element(fill_t fill);
    case (fill)
      FILL_WIDE:   return m3x3_pkg::ELEM_W'($urandom);
      FILL_NARROW: return m3x3_pkg::ELEM_W'($urandom_range(0, 1023)) - 16'd512;
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0100;
        endcase
      end
    endcase
  endfunction

  // Sampling of all three channels at the rising edge.
  always @(posedge clk) begin
    cell_t got;
    cell_t want;
    int    r;
    int    c;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) model_op = cfg_ch.operation;

      if (in_ch.valid && in_ch.ready) begin
        a_mem[load_pos]   = in_ch.a_element;
        b_mem[load_pos]   = in_ch.b_element;
        tag_mem[load_pos] = typed_tags.pop_front();
        load_pos++;
        if (load_pos == CELLS) begin
          load_pos = 0;
          batches_by_op[model_op]++;
          for (r = 0; r < DIM; r++) begin
            for (c = 0; c < DIM; c++) begin
              want.value = tag_mem[r * DIM + c].typed ? tag_mem[r * DIM + c].want
                                                      : result_cell(r, c, model_op);
              want.row   = m3x3_pkg::POS_W'(r);
              want.col   = m3x3_pkg::POS_W'(c);
              want.last  = (r == DIM - 1) && (c == DIM - 1);
              pending_results.push_back(want);
            end
          end
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        got.value = out_ch.result_element;
        got.row   = out_ch.row_index;
        got.col   = out_ch.column_index;
        got.last  = out_ch.last_result;
        if (pending_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected:", $time,
                   " value %0d row %0d col %0d last %0b",
                   got.value, got.row, got.col, got.last);
          errors++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got !== want) begin
            $display("%0t: expected value %0d row %0d col %0d last %0b,", $time,
                     want.value, want.row, want.col, want.last,
                     " got value %0d row %0d col %0d last %0b",
                     got.value, got.row, got.col, got.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
      $display("matrix3x3_add_sub_multiply_core_tb: errors");
      $finish;
    end
  end

  // Result sink with random back-pressure.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = snk_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Drops valid once after a transaction so that no step assigns it twice.
  task automatic release_source();
    if (src_driving) begin
      in_ch.valid <= 1'b0;
      src_driving = 1'b0;
    end
  endtask

  task automatic send_pair(logic [m3x3_pkg::ELEM_W-1:0] a, logic [m3x3_pkg::ELEM_W-1:0] b,
                           logic typed, logic signed [m3x3_pkg::RES_W-1:0] want);
    int   gap;
    tag_t tag;
    gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      release_source();
      repeat (gap) @(negedge clk);
    end
    tag.typed = typed;
    tag.want  = want;
    typed_tags.push_back(tag);
    in_ch.a_element <= a;
    in_ch.b_element <= b;
    in_ch.valid     <= 1'b1;
    src_driving = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    release_source();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // The operation register is only written once the core has gone quiet.
  task automatic write_op(logic [m3x3_pkg::OP_W-1:0] op);
    hold_until_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_ch.operation <= op;
    cfg_ch.valid     <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    fill_t     fill;
    stim_row_t row;
    int        n;
    int        i;
    int        mid;
    logic      even;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.a_element  = '0;
    in_ch.b_element  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.operation = OP_ADD;

    // Reset operation is multiply: most negative squared, summed three times.
    for (i = 0; i < CELLS; i++)
      directed_rows.push_back(make_row(1'b0, OP_ADD, 16'h8000, 16'h8000, 1'b1, 32'sd12582912));
    // Subtract is set, then add replaces it in the middle of the load.
    for (i = 0; i < CELLS; i++) begin
      even = (i % 2 == 0);
      directed_rows.push_back(make_row(i == 0 || i == 4,
                                       (i == 4) ? OP_ADD : m3x3_pkg::OP_SUB,
                                       even ? 16'h7FFF : 16'h8000, even ? 16'h7FFF : 16'h8000,
                                       1'b1, even ? 32'sd65534 : -32'sd65536));
    end
    // Subtract at both extremes of the 17-bit difference.
    for (i = 0; i < CELLS; i++) begin
      even = (i % 2 == 0);
      directed_rows.push_back(make_row(i == 0, m3x3_pkg::OP_SUB,
                                       even ? 16'h7FFF : 16'h8000, even ? 16'h8000 : 16'h7FFF,
                                       1'b1, even ? 32'sd65535 : -32'sd65535));
    end
    // Code three multiplies; a diagonal of -0.5 exercises floor rounding.
    for (i = 0; i < CELLS; i++)
      directed_rows.push_back(make_row(i == 0, OP_MUL_ALT,
                                       (i % 4 == 0) ? 16'hFF80 : 16'h0003, B_MIX[i],
                                       1'b0, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < directed_rows.size(); n++) begin
      row = directed_rows[n];
      if (row.set_op) write_op(row.op);
      send_pair(row.a, row.b, row.typed, row.want);
    end

    for (n = 0; n < RANDOM_BATCHES; n++) begin
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
      fill      = fill_t'($urandom_range(0, 2));
      if ($urandom_range(0, 2) == 0) write_op(m3x3_pkg::OP_W'($urandom_range(0, 3)));
      mid = ($urandom_range(0, 7) == 0) ? $urandom_range(1, CELLS - 1) : 0;
      for (i = 0; i < CELLS; i++) begin
        if (mid != 0 && i == mid) write_op(m3x3_pkg::OP_W'($urandom_range(0, 3)));
        send_pair(pick_element(fill), pick_element(fill), 1'b0, '0);
      end
      if ($urandom_range(0, 9) == 0) hold_until_drained();
    end

    write_op(OP_MUL);
    hold_until_drained();
    repeat (TAIL) @(negedge clk);

    $display("Ran %0d batches: %0d add, %0d subtract, %0d multiply, %0d multiply by code three.",
             batches_by_op[0] + batches_by_op[1] + batches_by_op[2] + batches_by_op[3],
             batches_by_op[0], batches_by_op[1], batches_by_op[2], batches_by_op[3]);
    $display("Compared %0d result transactions, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("matrix3x3_add_sub_multiply_core_tb: clean");
    end else begin
      $display("matrix3x3_add_sub_multiply_core_tb: errors");
    end
    $finish;
  end

endmodule
